### hdl/rlpd_pkg.sv
package rlpd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 56;
    localparam int RESULT_FIFO_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MONO_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TABLE = 2'd3;

    localparam logic [1:0] TARGET_ALL = 2'd0;
    localparam logic [1:0] TARGET_RED = 2'd1;
    localparam logic [1:0] TARGET_GREEN = 2'd2;
    localparam logic [1:0] TARGET_BLUE = 2'd3;

    localparam logic [2:0] RUN_CODE_SINGLE = 3'd0;

    typedef struct packed {
        logic [1:0]  target_plane;
        logic [31:0] start_offset;
        logic [8:0]  run_count;
        logic [7:0]  pixel_level;
        logic        image_done;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### hdl/rlpd_result_fifo.sv
module rlpd_result_fifo #(
    parameter int DEPTH = rlpd_pkg::RESULT_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rlpd_pkg::push_t   push,
    output logic              has_room,
    output logic              rd_valid,
    input  logic              rd_ready,
    output rlpd_pkg::result_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    rlpd_pkg::result_t storage_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_plus1;
    logic [PTR_W-1:0] tail_plus2;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        step_ptr = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign rd_valid = (count_reg != '0);
    assign rd_data = storage_reg[head_reg];
    assign has_room = (count_reg <= ROOM_LIMIT);
    assign pop = rd_valid && rd_ready;

    always_comb
    begin
        tail_plus1 = step_ptr(tail_reg);
        tail_plus2 = step_ptr(tail_plus1);
        head_next = pop ? step_ptr(head_reg) : head_reg;
        case (push.count)
            2'd1: tail_next = tail_plus1;
            2'd2: tail_next = tail_plus2;
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            storage_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            storage_reg[tail_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> has_room)
        else $error("Results were pushed into a queue without room for them.");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("Result queue count did not drop after a lone pop.");

endmodule

### hdl/planar_run_length_pixel_decoder.sv
// A code byte's results are written into the registered result queue when the byte is accepted.
// Throughput: one code byte per cycle while in_stall is low; a byte yields up to two
// results, two when it splits a run at a plane end, and results leave the queue at one per
// cycle while out_stall is low. Input stall rises when the queue cannot take two results.
// Reset is asynchronous and active low: settings clear to zero, the plane returns to red,
// the pixel count and the finished flag clear, and the result queue empties.
module planar_run_length_pixel_decoder #(
    parameter int FIFO_DEPTH = rlpd_pkg::RESULT_FIFO_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       code_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       target_plane,
    output logic [31:0]                      start_offset,
    output logic [8:0]                       run_count,
    output logic [7:0]                       pixel_level,
    output logic                             image_done,
    output logic                             last
);

    logic        mono_mode_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [55:0] run_table_reg;
    logic [31:0] plane_size_reg;
    logic [1:0]  plane_reg;
    logic [1:0]  plane_next;
    logic [31:0] pixels_reg;
    logic [31:0] pixels_next;
    logic        finished_reg;
    logic        finished_next;

    logic        cfg_fire;
    logic        in_fire;
    logic        has_room;
    logic [15:0] mul_a;
    logic [15:0] mul_b;

    logic [4:0]  level5;
    logic [7:0]  level;
    logic [2:0]  run_code;
    logic [2:0]  code_m1;
    logic [63:0] table_ext;
    logic [8:0]  run_len;
    logic [31:0] room;
    logic [8:0]  rem;
    logic [8:0]  cnt;
    logic [1:0]  plane_plus1;
    logic        last_plane;
    logic        r0_valid;
    logic        r1_valid;
    rlpd_pkg::result_t r0;
    rlpd_pkg::result_t r1;
    rlpd_pkg::result_t rd_data;
    rlpd_pkg::push_t   push;

    assign cfg_ready = 1'b1;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_stall = !has_room;
    assign in_fire = in_valid && !in_stall;

    assign mul_a = (cfg_index == rlpd_pkg::CFG_IMAGE_WIDTH) ? cfg_data[15:0] : image_width_reg;
    assign mul_b = (cfg_index == rlpd_pkg::CFG_IMAGE_HEIGHT) ? cfg_data[15:0] : image_height_reg;

    always_comb
    begin
        level5 = code_byte[4:0];
        level = {level5, level5[4:2]};
        run_code = code_byte[7:5];
        code_m1 = run_code - 3'd1;
        table_ext = {8'h00, run_table_reg};
        if (run_code == rlpd_pkg::RUN_CODE_SINGLE)
        begin
            run_len = 9'd1;
        end
        else
        begin
            run_len = {1'b0, table_ext[{code_m1, 3'b000} +: 8]} + 9'd1;
        end

        room = (pixels_reg >= plane_size_reg) ? 32'd0 : plane_size_reg - pixels_reg;
        rem = run_len - room[8:0];
        cnt = ({23'd0, rem} < plane_size_reg) ? rem : plane_size_reg[8:0];
        last_plane = (plane_reg == rlpd_pkg::TARGET_ALL) || (plane_reg == rlpd_pkg::TARGET_BLUE);
        plane_plus1 = plane_reg + 2'd1;

        plane_next = plane_reg;
        pixels_next = pixels_reg;
        finished_next = finished_reg;
        r0_valid = 1'b0;
        r1_valid = 1'b0;

        r0.target_plane = plane_reg;
        r0.start_offset = pixels_reg;
        r0.run_count = run_len;
        r0.pixel_level = level;
        r0.image_done = 1'b0;
        r0.last = 1'b0;

        r1.target_plane = plane_plus1;
        r1.start_offset = 32'd0;
        r1.run_count = cnt;
        r1.pixel_level = level;
        r1.image_done = 1'b0;
        r1.last = 1'b1;

        if (!finished_reg)
        begin
            if ({23'd0, run_len} < room)
            begin
                r0_valid = 1'b1;
                pixels_next = pixels_reg + {23'd0, run_len};
            end
            else
            begin
                r0_valid = (room != 32'd0);
                r0.run_count = room[8:0];
                r0.image_done = last_plane;
                if (last_plane)
                begin
                    finished_next = 1'b1;
                    pixels_next = plane_size_reg;
                end
                else
                begin
                    plane_next = plane_plus1;
                    pixels_next = 32'd0;
                    if (rem != 9'd0)
                    begin
                        r1_valid = (cnt != 9'd0);
                        pixels_next = {23'd0, cnt};
                        if ({23'd0, cnt} == plane_size_reg)
                        begin
                            if (plane_plus1 == rlpd_pkg::TARGET_BLUE)
                            begin
                                finished_next = 1'b1;
                                r1.image_done = 1'b1;
                            end
                            else
                            begin
                                plane_next = plane_plus1 + 2'd1;
                                pixels_next = 32'd0;
                            end
                        end
                    end
                end
            end
        end
        r0.last = !r1_valid;

        push.first = r0_valid ? r0 : r1;
        push.second = r1;
        if (!in_fire)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = {1'b0, r0_valid} + {1'b0, r1_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_mode_reg <= 1'b0;
            image_width_reg <= '0;
            image_height_reg <= '0;
            run_table_reg <= '0;
            plane_size_reg <= '0;
            plane_reg <= rlpd_pkg::TARGET_RED;
            pixels_reg <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    rlpd_pkg::CFG_MONO_MODE:
                    begin
                        mono_mode_reg <= cfg_data[0];
                        plane_reg <= cfg_data[0] ? rlpd_pkg::TARGET_ALL : rlpd_pkg::TARGET_RED;
                    end
                    rlpd_pkg::CFG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data[15:0];
                        plane_size_reg <= {16'd0, mul_a} * {16'd0, mul_b};
                    end
                    rlpd_pkg::CFG_IMAGE_HEIGHT:
                    begin
                        image_height_reg <= cfg_data[15:0];
                        plane_size_reg <= {16'd0, mul_a} * {16'd0, mul_b};
                    end
                    rlpd_pkg::CFG_RUN_TABLE:
                    begin
                        run_table_reg <= cfg_data;
                    end
                    default:
                    begin
                        run_table_reg <= run_table_reg;
                    end
                endcase
            end
            else if (in_fire)
            begin
                plane_reg <= plane_next;
                pixels_reg <= pixels_next;
                finished_reg <= finished_next;
            end
        end
    end

    rlpd_result_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_result_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .has_room(has_room),
        .rd_valid(out_valid),
        .rd_ready(!out_stall),
        .rd_data(rd_data)
    );

    assign target_plane = rd_data.target_plane;
    assign start_offset = rd_data.start_offset;
    assign run_count = rd_data.run_count;
    assign pixel_level = rd_data.pixel_level;
    assign image_done = rd_data.image_done;
    assign last = rd_data.last;

    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && finished_reg) |-> (push.count == 2'd0))
        else $error("A code byte after the image was finished produced a result.");

    a_nonempty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (push.first.run_count != 9'd0))
        else $error("An empty run was pushed as a result.");

    a_done_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_fire && ((r0_valid && r0.image_done) || (r1_valid && r1.image_done)))
        |=> finished_reg)
        else $error("A result flagged the image done but the decoder did not finish.");

    a_mono_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (mono_mode_reg && !cfg_fire) |=> (plane_reg == rlpd_pkg::TARGET_ALL))
        else $error("Mono mode left the all-planes target.");

endmodule

### test/planar_run_length_pixel_decoder_test.sv
module planar_run_length_pixel_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        mono;
        logic [15:0] width;
        logic [15:0] height;
        logic [55:0] run_lengths;
        logic [1:0]  plane;
        logic [31:0] filled;
        logic        finished;
    } decoder_state_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rlpd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rlpd_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [7:0]                       code_byte;
    logic                             out_valid;
    logic                             out_stall;
    logic [1:0]                       target_plane;
    logic [31:0]                      start_offset;
    logic [8:0]                       run_count;
    logic [7:0]                       pixel_level;
    logic                             image_done;
    logic                             last;

    decoder_state_t    decoder;
    rlpd_pkg::result_t expected_runs[$];
    int                mismatch_count;
    int                random_codes_sent;
    bit                finish_allowed;
    bit                in_idle_on;
    bit                out_idle_on;

    planar_run_length_pixel_decoder dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("planar_run_length_pixel_decoder: mismatch");
        $finish;
    end

    function automatic rlpd_pkg::result_t make_run(input logic [1:0] plane,
                                                   input logic [31:0] offset,
                                                   input logic [31:0] count,
                                                   input logic [7:0] level,
                                                   input logic done);
        rlpd_pkg::result_t r;
        r.target_plane = plane;
        r.start_offset = offset;
        r.run_count    = count[8:0];
        r.pixel_level  = level;
        r.image_done   = done;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void decode_code(ref decoder_state_t s, input logic [7:0] code,
                                        ref rlpd_pkg::result_t runs[$]);
        logic [7:0]        level;
        logic [31:0]       len;
        logic [31:0]       size;
        logic [31:0]       room;
        logic [31:0]       rest;
        logic [31:0]       cnt;
        logic              last_plane;
        rlpd_pkg::result_t piece[2];
        int                n;
        n = 0;
        if (s.finished)
            return;
        level = {code[4:0], code[4:2]};
        if (code[7:5] == rlpd_pkg::RUN_CODE_SINGLE)
            len = 32'd1;
        else
            len = 32'(s.run_lengths[(code[7:5] - 1) * 8 +: 8]) + 32'd1;
        size = 32'(s.width) * 32'(s.height);
        room = (s.filled >= size) ? 32'd0 : size - s.filled;
        if (len < room)
        begin
            piece[n] = make_run(s.plane, s.filled, len, level, 1'b0);
            n++;
            s.filled = s.filled + len;
        end
        else
        begin
            rest = len - room;
            last_plane = (s.plane == rlpd_pkg::TARGET_ALL) || (s.plane == rlpd_pkg::TARGET_BLUE);
            if (room > 0)
            begin
                piece[n] = make_run(s.plane, s.filled, room, level, last_plane);
                n++;
            end
            if (last_plane)
            begin
                s.finished = 1'b1;
                s.filled = size;
            end
            else
            begin
                s.plane = s.plane + 2'd1;
                s.filled = 32'd0;
                if (rest > 0)
                begin
                    cnt = (rest < size) ? rest : size;
                    if (cnt > 0)
                    begin
                        piece[n] = make_run(s.plane, 32'd0, cnt, level,
                                            cnt == size && s.plane == rlpd_pkg::TARGET_BLUE);
                        n++;
                    end
                    s.filled = cnt;
                    if (cnt == size)
                    begin
                        if (s.plane == rlpd_pkg::TARGET_BLUE)
                            s.finished = 1'b1;
                        else
                        begin
                            s.plane = s.plane + 2'd1;
                            s.filled = 32'd0;
                        end
                    end
                end
            end
        end
        if (n > 0)
            piece[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            runs.push_back(piece[i]);
    endfunction

    function automatic void apply_register(input logic [rlpd_pkg::CFG_INDEX_W-1:0] index,
                                           input logic [rlpd_pkg::CFG_DATA_W-1:0] data);
        case (index)
            rlpd_pkg::CFG_MONO_MODE:
            begin
                decoder.mono = data[0];
                decoder.plane = data[0] ? rlpd_pkg::TARGET_ALL : rlpd_pkg::TARGET_RED;
            end
            rlpd_pkg::CFG_IMAGE_WIDTH:  decoder.width = data[15:0];
            rlpd_pkg::CFG_IMAGE_HEIGHT: decoder.height = data[15:0];
            rlpd_pkg::CFG_RUN_TABLE:    decoder.run_lengths = data[55:0];
            default:                    ;
        endcase
    endfunction

    function automatic logic [55:0] random_lengths();
        return 56'({$urandom(), $urandom()});
    endfunction

    function automatic logic [15:0] random_dimension();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic report_mismatch(input string why, input rlpd_pkg::result_t want,
                                   input rlpd_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected plane %0d offset %0d count %0d level %0d done %0b last %0b,",
                     why, want.target_plane, want.start_offset, want.run_count,
                     want.pixel_level, want.image_done, want.last,
                     " got plane %0d offset %0d count %0d level %0d done %0b last %0b",
                     got.target_plane, got.start_offset, got.run_count,
                     got.pixel_level, got.image_done, got.last);
    endtask

    always @(posedge clk)
    begin
        rlpd_pkg::result_t got;
        rlpd_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {target_plane, start_offset, run_count, pixel_level, image_done, last};
            if (expected_runs.size() == 0)
                report_mismatch("unexpected run", '0, got);
            else
            begin
                want = expected_runs.pop_front();
                if (got.target_plane !== want.target_plane
                    || got.start_offset !== want.start_offset
                    || got.run_count !== want.run_count
                    || got.pixel_level !== want.pixel_level
                    || got.image_done !== want.image_done
                    || got.last !== want.last)
                    report_mismatch("run mismatch", want, got);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [rlpd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [rlpd_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(index, data);
        @(negedge clk);
    endtask

    task automatic set_image(input logic mono, input logic [15:0] width,
                             input logic [15:0] height, input logic [55:0] lengths);
        wait_for_idle();
        write_register(rlpd_pkg::CFG_MONO_MODE,
                       {random_lengths() & 56'hff_ffff_ffff_fffe} | mono);
        write_register(rlpd_pkg::CFG_IMAGE_WIDTH, rlpd_pkg::CFG_DATA_W'(width));
        write_register(rlpd_pkg::CFG_IMAGE_HEIGHT, rlpd_pkg::CFG_DATA_W'(height));
        write_register(rlpd_pkg::CFG_RUN_TABLE, lengths);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_code(input logic [7:0] code);
        decoder_state_t    trial;
        rlpd_pkg::result_t scratch[$];
        trial = decoder;
        decode_code(trial, code, scratch);
        // Finishing the image is permanent, so until the closing test a code that
        // would finish it is preceded by a return to the red plane.
        if (trial.finished && !decoder.finished && !finish_allowed)
        begin
            wait_for_idle();
            write_register(rlpd_pkg::CFG_MONO_MODE, '0);
            cfg_valid <= 1'b0;
        end
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_code(decoder, code, expected_runs);
        @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_code(8'h00);
        send_code(8'h3f);
    endtask

    task automatic test_codes_and_levels();
        logic [7:0] codes[11] = '{8'h00, 8'h1f, 8'h10, 8'h2a, 8'h55, 8'h7f,
                                  8'h80, 8'hab, 8'hd4, 8'hff, 8'he0};
        set_image(1'b0, 16'd100, 16'd100, 56'h10_fe_80_7f_01_ff_00);
        foreach (codes[i])
            send_code(codes[i]);
    endtask

    task automatic test_plane_crossing();
        logic [7:0] codes[10] = '{8'h21, 8'h42, 8'h03, 8'h62, 8'h85,
                                  8'ha6, 8'h27, 8'hc8, 8'he9, 8'h1b};
        set_image(1'b0, 16'd10, 16'd3, 56'h00_04_13_ff_27_1d_09);
        foreach (codes[i])
            send_code(codes[i]);
        set_image(1'b1, 16'd10, 16'd3, 56'h00_04_13_ff_27_1d_09);
        send_code(8'h0a);
        send_code(8'h2b);
        set_image(1'b0, 16'd0, 16'd5, 56'h00_04_13_ff_27_1d_09);
        send_code(8'h21);
        send_code(8'h22);
        set_image(1'b0, 16'hffff, 16'hffff, 56'hff_ff_ff_ff_ff_ff_ff);
        send_code(8'hff);
        send_code(8'he0);
    endtask

    task automatic test_random_runs(input int target);
        bit first_phase;
        first_phase = 1'b1;
        while (random_codes_sent < target)
        begin
            if (first_phase || $urandom_range(0, 2) != 0)
                set_image($urandom_range(0, 3) == 0, random_dimension(), random_dimension(),
                          $urandom_range(0, 5) == 0 ? 56'd0 :
                          $urandom_range(0, 4) == 0 ? {56{1'b1}} : random_lengths());
            else
            begin
                wait_for_idle();
                write_register(rlpd_pkg::CFG_IMAGE_WIDTH,
                               rlpd_pkg::CFG_DATA_W'(random_dimension()));
                if ($urandom_range(0, 1) == 0)
                    write_register(rlpd_pkg::CFG_IMAGE_HEIGHT,
                                   rlpd_pkg::CFG_DATA_W'(random_dimension()));
                cfg_valid <= 1'b0;
            end
            first_phase = 1'b0;
            in_idle_on  = $urandom_range(0, 3) != 0;
            out_idle_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(20, 80))
            begin
                send_code(8'($urandom_range(0, 255)));
                random_codes_sent++;
            end
        end
    endtask

    task automatic test_steady_stream();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        set_image(1'b0, 16'($urandom_range(2, 9)), 16'($urandom_range(2, 9)),
                  random_lengths());
        repeat (60)
            send_code(8'($urandom_range(0, 255)));
    endtask

    task automatic test_image_completion();
        finish_allowed = 1'b1;
        set_image($urandom_range(0, 1), 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                  random_lengths());
        while (!decoder.finished)
            send_code(8'($urandom_range(0, 255)));
        repeat (4)
            send_code(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        code_byte      = '0;
        mismatch_count = 0;
        random_codes_sent = 0;
        finish_allowed = 1'b0;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        decoder.mono        = 1'b0;
        decoder.width       = '0;
        decoder.height      = '0;
        decoder.run_lengths = '0;
        decoder.plane       = rlpd_pkg::TARGET_RED;
        decoder.filled      = '0;
        decoder.finished    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_codes_and_levels();
        test_plane_crossing();
        test_random_runs(1400);
        test_steady_stream();
        test_image_completion();

        wait_for_idle();
        repeat (10) @(negedge clk);
        if (expected_runs.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("planar_run_length_pixel_decoder: match");
        else
            $display("planar_run_length_pixel_decoder: mismatch");
        $finish;
    end

endmodule
